[sv/mh2_pkg.sv]
// Shared constants and item types for the streaming MurmurHash2 block.
package mh2_pkg;

    localparam logic [31:0] MIX_MULT  = 32'h5bd1e995;
    localparam logic [31:0] HASH_SEED = 32'd5381;
    localparam int          SHIFT_K   = 24;
    localparam int          SHIFT_F1  = 13;
    localparam int          SHIFT_F2  = 15;

    typedef logic [1:0] t_kind;

    localparam t_kind KIND_NONE = 2'd0;
    localparam t_kind KIND_FULL = 2'd1;
    localparam t_kind KIND_TAIL = 2'd2;

    // data: premixed k for a full word, masked tail bytes for a partial word
    typedef struct packed {
        logic [31:0] data;
        t_kind       kind;
        logic        first;
        logic        last;
        logic [30:0] len;
    } t_item;

endpackage

[sv/murmur2_hash_32_top.sv]
// Top level of the streaming 32-bit MurmurHash2 block.
//
// Input channel: a key arrives as 32-bit little-endian words; i_push with o_full
// low transfers one word. i_first marks the first word and seeds the hash with
// 5381 ^ i_total_length; i_byte_count gives the valid bytes (4..7 = full word,
// 1..3 = tail, 0 = no data); i_last closes the key.
// Result channel: o_hash holds the oldest finished hash while o_empty is low;
// i_pop transfers it. Exactly one result follows each word with i_last set.
// Throughput: one word per cycle while o_full is low, set by the single running-hash
// multiply in the back end. Path from the input transfer of a last word to o_empty
// going low: two premix stages, the middle queue, the recurrence, the finish
// multiply and the result queue.
// A stalled result side fills the result queue, then the middle queue, then
// raises o_full; nothing is dropped.
// Reset (i_rst_n low, synchronous) empties both queues and clears the
// running hash to zero.
module murmur2_hash_32_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    output logic         o_full,
    input  logic [31:0]  i_word,
    input  logic [2:0]   i_byte_count,
    input  logic         i_first,
    input  logic         i_last,
    input  logic [30:0]  i_total_length,
    output logic         o_empty,
    input  logic         i_pop,
    output logic [31:0]  o_hash
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic                w_item_valid;
    mh2_pkg::t_item      w_item_in;
    mh2_pkg::t_item      w_item_out;
    logic [$bits(mh2_pkg::t_item)-1:0] w_q_data;
    logic                w_item_empty;
    logic                w_item_pop;
    logic [CNT_W-1:0]    w_item_cnt;

    mh2_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (i_push),
        .o_full         (o_full),
        .i_word         (i_word),
        .i_byte_count   (i_byte_count),
        .i_first        (i_first),
        .i_last         (i_last),
        .i_total_length (i_total_length),
        .i_count        (w_item_cnt),
        .o_item_valid   (w_item_valid),
        .o_item         (w_item_in)
    );

    mh2_fifo #(
        .WIDTH ($bits(mh2_pkg::t_item)),
        .DEPTH (QUEUE_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_item_valid),
        .i_data  (w_item_in),
        .i_pop   (w_item_pop),
        .o_empty (w_item_empty),
        .o_count (w_item_cnt),
        .o_data  (w_q_data)
    );

    assign w_item_out = mh2_pkg::t_item'(w_q_data);

    mh2_back #(
        .DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_empty (w_item_empty),
        .i_item       (w_item_out),
        .o_item_pop   (w_item_pop),
        .i_pop        (i_pop),
        .o_empty      (o_empty),
        .o_hash       (o_hash)
    );

endmodule

[sv/mh2_fifo.sv]
// Small register queue with occupancy count, used between and after the hash stages.
module mh2_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  logic [WIDTH-1:0]               i_data,
    input  logic                           i_pop,
    output logic                           o_empty,
    output logic [$clog2(DEPTH+1)-1:0]     o_count,
    output logic [WIDTH-1:0]               o_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic             w_wr, w_rd;

    assign w_rd    = i_pop && (r_cnt != '0);
    assign w_wr    = i_push && (r_cnt != CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
            end
            if (w_rd) begin
                r_rp <= (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + PTR_W'(1);
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

[sv/mh2_front.sv]
// Front end: accepts key words, classifies them and premixes full words in two stages.
module mh2_front #(
    parameter int DEPTH = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    output logic                           o_full,
    input  logic [31:0]                    i_word,
    input  logic [2:0]                     i_byte_count,
    input  logic                           i_first,
    input  logic                           i_last,
    input  logic [30:0]                    i_total_length,
    input  logic [$clog2(DEPTH+1)-1:0]     i_count,
    output logic                           o_item_valid,
    output mh2_pkg::t_item                 o_item
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                r_v1, r_v2;
    logic [31:0]         r_k1;
    mh2_pkg::t_kind      r_kind1;
    logic                r_first1, r_last1;
    logic [30:0]         r_len1;
    mh2_pkg::t_item      r_item2;

    logic                w_accept;
    logic [CNT_W:0]      w_used;
    mh2_pkg::t_kind      n_kind1;
    logic [31:0]         n_k1;
    logic [31:0]         w_k1x;
    logic [31:0]         n_data2;

    // stored plus in-flight items bound the queue occupancy
    assign w_used   = (CNT_W+1)'(i_count) + (CNT_W+1)'(r_v1) + (CNT_W+1)'(r_v2);
    assign o_full   = (w_used >= (CNT_W+1)'(DEPTH));
    assign w_accept = i_push && !o_full;

    always_comb begin
        priority if (i_byte_count == 3'd0) begin
            n_kind1 = mh2_pkg::KIND_NONE;
            n_k1    = i_word;
        end else if (i_byte_count >= 3'd4) begin
            n_kind1 = mh2_pkg::KIND_FULL;
            n_k1    = i_word * mh2_pkg::MIX_MULT;
        end else if (i_byte_count == 3'd1) begin
            n_kind1 = mh2_pkg::KIND_TAIL;
            n_k1    = i_word & 32'h0000_00ff;
        end else if (i_byte_count == 3'd2) begin
            n_kind1 = mh2_pkg::KIND_TAIL;
            n_k1    = i_word & 32'h0000_ffff;
        end else begin
            n_kind1 = mh2_pkg::KIND_TAIL;
            n_k1    = i_word & 32'h00ff_ffff;
        end
    end

    assign w_k1x   = r_k1 ^ (r_k1 >> mh2_pkg::SHIFT_K);
    assign n_data2 = (r_kind1 == mh2_pkg::KIND_FULL) ? w_k1x * mh2_pkg::MIX_MULT : r_k1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= w_accept;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_k1     <= n_k1;
            r_kind1  <= n_kind1;
            r_first1 <= i_first;
            r_last1  <= i_last;
            r_len1   <= i_total_length;
        end
        if (r_v1) begin
            r_item2.data  <= n_data2;
            r_item2.kind  <= r_kind1;
            r_item2.first <= r_first1;
            r_item2.last  <= r_last1;
            r_item2.len   <= r_len1;
        end
    end

    assign o_item_valid = r_v2;
    assign o_item       = r_item2;

endmodule

[sv/mh2_back.sv]
// Back end: running-hash recurrence, final mixes and the result queue.
module mh2_back #(
    parameter int DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_item_empty,
    input  mh2_pkg::t_item      i_item,
    output logic                o_item_pop,
    input  logic                i_pop,
    output logic                o_empty,
    output logic [31:0]         o_hash
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [31:0]         r_h;
    logic                r_fv1, r_fv2;
    logic [31:0]         r_f2;

    logic [31:0]         w_base;
    logic [31:0]         w_op;
    logic [31:0]         w_prod;
    logic [31:0]         n_h;
    logic [31:0]         w_f1;
    logic [CNT_W-1:0]    w_out_cnt;
    logic [CNT_W:0]      w_used;

    // results in the finish stages are counted against the result queue
    assign w_used     = (CNT_W+1)'(w_out_cnt) + (CNT_W+1)'(r_fv1) + (CNT_W+1)'(r_fv2);
    assign o_item_pop = !i_item_empty && (w_used < (CNT_W+1)'(DEPTH));

    assign w_base = i_item.first ? (mh2_pkg::HASH_SEED ^ {1'b0, i_item.len}) : r_h;
    assign w_op   = (i_item.kind == mh2_pkg::KIND_TAIL) ? (w_base ^ i_item.data) : w_base;
    assign w_prod = w_op * mh2_pkg::MIX_MULT;

    always_comb begin
        unique case (i_item.kind)
            mh2_pkg::KIND_FULL: n_h = w_prod ^ i_item.data;
            mh2_pkg::KIND_TAIL: n_h = w_prod;
            default:            n_h = w_base;
        endcase
    end

    assign w_f1 = r_h ^ (r_h >> mh2_pkg::SHIFT_F1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h   <= '0;
            r_fv1 <= 1'b0;
            r_fv2 <= 1'b0;
        end else begin
            if (o_item_pop) begin
                r_h <= n_h;
            end
            r_fv1 <= o_item_pop && i_item.last;
            r_fv2 <= r_fv1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_fv1) begin
            r_f2 <= w_f1 * mh2_pkg::MIX_MULT;
        end
    end

    mh2_fifo #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_fv2),
        .i_data  (r_f2 ^ (r_f2 >> mh2_pkg::SHIFT_F2)),
        .i_pop   (i_pop),
        .o_empty (o_empty),
        .o_count (w_out_cnt),
        .o_data  (o_hash)
    );

endmodule

[dv/tb_top.sv]
// Self-checking testbench for the streaming MurmurHash2 block, with its hash scoreboard.
`timescale 1ns / 100ps

module tb_top;
    import mh2_pkg::*;

    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_ITEMS = 1800;

    // Predicts the hash of each key from accepted words and checks popped hashes.
    class hash_scoreboard;
        logic [31:0] run_hash = '0;
        logic [31:0] hash_q[$];
        int          errors = 0;

        function void note_word(logic [31:0] word, logic [2:0] cnt, logic first,
                                logic last, logic [30:0] len);
            logic [31:0] h;
            logic [31:0] k;
            logic [31:0] mask;
            int          n;
            n = (cnt > 3'd4) ? 4 : int'(cnt);
            h = first ? (HASH_SEED ^ {1'b0, len}) : run_hash;
            if (n == 4) begin
                k = word * MIX_MULT;
                k = k ^ (k >> SHIFT_K);
                k = k * MIX_MULT;
                h = (h * MIX_MULT) ^ k;
            end else if (n != 0) begin
                mask = 32'hffff_ffff >> (8 * (4 - n));
                h = (h ^ (word & mask)) * MIX_MULT;
            end
            run_hash = h;
            if (last) begin
                h = h ^ (h >> SHIFT_F1);
                h = h * MIX_MULT;
                h = h ^ (h >> SHIFT_F2);
                hash_q.push_back(h);
            end
        endfunction

        function void check_hash(logic [31:0] got);
            logic [31:0] exp_hash;
            if (hash_q.size() == 0) begin
                $display("%0t: unexpected hash, expected none, actual %h", $time, got);
                errors++;
            end else begin
                exp_hash = hash_q.pop_front();
                if (got !== exp_hash) begin
                    $display("%0t: hash mismatch, expected %h, actual %h",
                             $time, exp_hash, got);
                    errors++;
                end
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_push;
    logic        o_full;
    logic [31:0] i_word;
    logic [2:0]  i_byte_count;
    logic        i_first;
    logic        i_last;
    logic [30:0] i_total_length;
    logic        o_empty;
    logic        i_pop;
    logic [31:0] o_hash;

    hash_scoreboard scoreboard = new();
    bit             calm;
    int             words_sent;
    int             idle_cycles;

    murmur2_hash_32_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (i_push),
        .o_full         (o_full),
        .i_word         (i_word),
        .i_byte_count   (i_byte_count),
        .i_first        (i_first),
        .i_last         (i_last),
        .i_total_length (i_total_length),
        .o_empty        (o_empty),
        .i_pop          (i_pop),
        .o_hash         (o_hash)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic push_word(input logic [31:0] word, input logic [2:0] cnt,
                             input logic first, input logic last,
                             input logic [30:0] len);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            i_push = 1'b0;
        end
        @(negedge i_clk);
        i_push         = 1'b1;
        i_word         = word;
        i_byte_count   = cnt;
        i_first        = first;
        i_last         = last;
        i_total_length = len;
        do @(posedge i_clk); while (o_full);
        words_sent++;
    endtask

    // Well-formed key; len_field seeds the hash, usually the true length.
    task automatic send_key(input int n_bytes, input logic [30:0] len_field);
        int         n_full;
        int         tail;
        int         n_items;
        bit         trail_empty;
        logic [2:0] cnt;
        n_full      = n_bytes / 4;
        tail        = n_bytes % 4;
        trail_empty = (tail == 0) && (n_bytes > 0) && ($urandom_range(0, 7) == 0);
        n_items     = n_full + (tail > 0) + trail_empty;
        if (n_items == 0) n_items = 1;
        for (int i = 0; i < n_items; i++) begin
            if (i < n_full) begin
                cnt = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7)) : 3'd4;
            end else begin
                cnt = 3'(tail);
            end
            push_word($urandom, cnt, i == 0, i == n_items - 1,
                      (i == 0) ? len_field : 31'($urandom));
        end
    endtask

    initial begin
        i_pop = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            int stall;
            stall = pick_gap();
            @(negedge i_clk);
            i_pop = (stall == 0);
            repeat (stall) @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_push && !o_full) begin
                scoreboard.note_word(i_word, i_byte_count, i_first, i_last, i_total_length);
            end
            if (i_pop && !o_empty) begin
                scoreboard.check_hash(o_hash);
            end
            if ((i_push && !o_full) || (i_pop && !o_empty)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles == IDLE_LIMIT) begin
                $display("%0t: watchdog expired, %0d hashes outstanding",
                         $time, scoreboard.hash_q.size());
                $display("tb_top: done, errors");
                $finish;
            end
        end
    end

    initial begin
        int r;
        int n_bytes;
        i_rst_n        = 1'b0;
        i_push         = 1'b0;
        i_word         = '0;
        i_byte_count   = '0;
        i_first        = 1'b0;
        i_last         = 1'b0;
        i_total_length = '0;
        calm           = 1'b0;
        words_sent     = 0;
        idle_cycles    = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // continue from the cleared hash without a first word
        push_word(32'h1234_5678, 3'd4, 1'b0, 1'b1, 31'h0);
        // empty key, word bits ignored
        push_word(32'hdead_beef, 3'd0, 1'b1, 1'b1, 31'd0);
        push_word(32'h0000_0000, 3'd4, 1'b1, 1'b1, 31'd4);
        push_word(32'hffff_ffff, 3'd4, 1'b1, 1'b1, 31'd4);
        // tails with junk in unused bytes
        push_word(32'hffff_ffff, 3'd1, 1'b1, 1'b1, 31'd1);
        push_word(32'hffff_ffff, 3'd2, 1'b1, 1'b1, 31'd2);
        push_word(32'hffff_ffff, 3'd3, 1'b1, 1'b1, 31'd3);
        // counts above four saturate
        push_word(32'ha5a5_a5a5, 3'd5, 1'b1, 1'b0, 31'd12);
        push_word(32'h5a5a_5a5a, 3'd6, 1'b0, 1'b0, 31'h7fff_ffff);
        push_word(32'h0f0f_0f0f, 3'd7, 1'b0, 1'b1, 31'h0);
        // zero-count word inside a key
        push_word(32'h6463_6261, 3'd4, 1'b1, 1'b0, 31'd8);
        push_word(32'hffff_ffff, 3'd0, 1'b0, 1'b0, 31'd0);
        push_word(32'h6867_6665, 3'd4, 1'b0, 1'b1, 31'd8);
        // partial word before the last
        push_word(32'hcafe_babe, 3'd2, 1'b1, 1'b0, 31'd7);
        push_word(32'h8000_0001, 3'd4, 1'b0, 1'b0, 31'd0);
        push_word(32'h7fff_fffe, 3'd1, 1'b0, 1'b1, 31'd0);
        // total length extremes and patterns, not matching the bytes sent
        push_word(32'haaaa_aaaa, 3'd4, 1'b1, 1'b1, 31'h7fff_ffff);
        push_word(32'h5555_5555, 3'd4, 1'b1, 1'b1, 31'h2aaa_aaaa);
        push_word(32'h3333_3333, 3'd3, 1'b1, 1'b1, 31'h5555_5555);
        // continue after a finished key
        push_word(32'h0123_4567, 3'd4, 1'b0, 1'b1, 31'h1234_5678);
        push_word(32'h89ab_cdef, 3'd0, 1'b0, 1'b1, 31'h0);
        // first again mid-key reseeds
        push_word(32'hfeed_f00d, 3'd4, 1'b1, 1'b0, 31'd8);
        push_word(32'h1357_9bdf, 3'd4, 1'b1, 1'b1, 31'd8);

        while (words_sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 19) == 0) calm = ~calm;
            r = $urandom_range(0, 99);
            if (r < 85) begin
                r = $urandom_range(0, 99);
                if (r < 70)      n_bytes = $urandom_range(0, 24);
                else if (r < 95) n_bytes = $urandom_range(25, 64);
                else             n_bytes = $urandom_range(65, 160);
                send_key(n_bytes, ($urandom_range(0, 9) == 0) ? 31'($urandom)
                                                              : 31'(n_bytes));
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    push_word($urandom, 3'($urandom_range(0, 7)), 1'($urandom),
                              1'($urandom), 31'($urandom));
                end
            end
        end

        @(negedge i_clk);
        i_push = 1'b0;
        while (scoreboard.hash_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (scoreboard.errors == 0 && scoreboard.hash_q.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
